// ===== sv/btnode_pkg.sv =====
// Shared constants, codes and controller/datapath command types for the node table.
package btnode_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int KEY_BITS_DEF    = 32;

   localparam int OP_W     = 3;
   localparam int KEY_W    = 32;
   localparam int CHILD_W  = 31;
   localparam int SLOT_W   = 7;
   localparam int STAT_W   = 3;
   localparam int CFG_W    = 7;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [CFG_W-1:0] CFG_MAX_RESET = 7'd64;

   // register index of max_entries
   localparam logic CSR_IDX_MAX_ENTRIES = 1'b0;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
   localparam logic [OP_W-1:0] OP_NEW_ROOT   = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND_CHILD = 3'd4;
   localparam logic [OP_W-1:0] OP_READ       = 3'd5;
   localparam logic [OP_W-1:0] OP_SET_KEY    = 3'd6;
   localparam logic [OP_W-1:0] OP_TAKE_ONLY  = 3'd7;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   // scan index load source
   localparam logic [1:0] IX_ONE   = 2'd0;
   localparam logic [1:0] IX_ZERO  = 2'd1;
   localparam logic [1:0] IX_COUNT = 2'd2;
   localparam logic [1:0] IX_SLOT  = 2'd3;

   // memory read address source
   localparam logic [2:0] RD_IDX    = 3'd0;
   localparam logic [2:0] RD_IDX_M1 = 3'd1;
   localparam logic [2:0] RD_IDX_P1 = 3'd2;
   localparam logic [2:0] RD_BEST   = 3'd3;
   localparam logic [2:0] RD_SLOT   = 3'd4;
   localparam logic [2:0] RD_ZERO   = 3'd5;

   // memory write kind
   localparam logic [2:0] WR_NONE   = 3'd0;
   localparam logic [2:0] WR_SHIFT  = 3'd1;
   localparam logic [2:0] WR_INS    = 3'd2;
   localparam logic [2:0] WR_ROOT0  = 3'd3;
   localparam logic [2:0] WR_ROOT1  = 3'd4;
   localparam logic [2:0] WR_SETKEY = 3'd5;

   // entry count update
   localparam logic [2:0] CN_HOLD = 3'd0;
   localparam logic [2:0] CN_INC  = 3'd1;
   localparam logic [2:0] CN_DEC  = 3'd2;
   localparam logic [2:0] CN_TWO  = 3'd3;
   localparam logic [2:0] CN_ZERO = 3'd4;

   typedef struct packed {
      logic              load;
      logic              idx_set;
      logic [1:0]        idx_src;
      logic              idx_inc;
      logic              idx_dec;
      logic              rd_en;
      logic [2:0]        rd_src;
      logic              cmp_key;
      logic              pos_load;
      logic [2:0]        wr_kind;
      logic [2:0]        cnt_op;
      logic              res_child;
      logic              res_key;
      logic              res_slot_idx;
      logic              res_slot_at;
      logic              status_set;
      logic [STAT_W-1:0] status;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            count_zero;
      logic            count_one;
      logic            slot_bad;
      logic            full;
      logic            scan_end;
      logic            child_hit;
      logic            ins_done;
      logic            rem_done;
   } stat_type;

endpackage

// ===== sv/btnode_ifs.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface btnode_req_if;
   logic                                valid;
   logic                                ready;
   logic [btnode_pkg::OP_W-1:0]         op;
   logic signed [btnode_pkg::KEY_W-1:0] search_key;
   logic [btnode_pkg::CHILD_W-1:0]      new_child;
   logic [btnode_pkg::CHILD_W-1:0]      anchor_child;
   logic [btnode_pkg::SLOT_W-1:0]       slot;

   modport source (output valid, op, search_key, new_child, anchor_child, slot,
                   input ready);
   modport sink   (input valid, op, search_key, new_child, anchor_child, slot,
                   output ready);
endinterface

interface btnode_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [btnode_pkg::CHILD_W-1:0]      found_child;
   logic signed [btnode_pkg::KEY_W-1:0] found_key;
   logic [btnode_pkg::SLOT_W-1:0]       found_slot;
   logic [btnode_pkg::SLOT_W-1:0]       entry_total;
   logic [btnode_pkg::STAT_W-1:0]       status;

   modport source (output valid, found_child, found_key, found_slot, entry_total, status,
                   input ready);
   modport sink   (input valid, found_child, found_key, found_slot, entry_total, status,
                   output ready);
endinterface

// ===== sv/btree_internal_node_table.sv =====
// Top level of the B+ tree internal node table: ports, config register, controller, datapath.
//
//   channel   direction  handshake        carries
//   req_chan  in         valid/ready      op, search_key, new_child, anchor_child, slot
//   rsp_chan  out        valid/ready      found_child, found_key, found_slot, entry_total, status
//   APB       in         psel/penable     max_entries write/read, pready tied high
//
// One transaction is worked at a time. The entry memory has one read port with a
// registered output, so scans and shifts read each entry in a check state and then
// use it in a separate compare or move state.
// Reset is synchronous; it empties the node and sets max_entries to 64.
// A finished response waits in the output register; the next request is taken meanwhile.
module btree_internal_node_table #(
   parameter int MAX_ENTRIES = btnode_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_BITS    = btnode_pkg::KEY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   btnode_req_if.sink                         req_chan,
   btnode_rsp_if.source                       rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [btnode_pkg::PADDR_W-1:0]     paddr,
   input  logic [btnode_pkg::PDATA_W-1:0]     pwdata,
   output logic [btnode_pkg::PDATA_W-1:0]     prdata,
   output logic                               pready
);
   btnode_pkg::cmd_type            cmd;
   btnode_pkg::stat_type           stat;
   logic [btnode_pkg::CFG_W-1:0]   max_ff;
   logic                           csr_wr;
   logic                           csr_hit;

   // Register index is paddr[2]; the low two address bits are byte lanes.
   assign pready  = 1'b1;
   assign csr_hit = paddr[2] == btnode_pkg::CSR_IDX_MAX_ENTRIES;
   assign csr_wr  = psel && penable && pwrite && csr_hit;
   assign prdata  = csr_hit ? btnode_pkg::PDATA_W'(max_ff) : '0;

   // Hold the fan-out limit; writes to other indexes drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= btnode_pkg::CFG_MAX_RESET;
      end else if (csr_wr) begin
         max_ff <= pwdata[btnode_pkg::CFG_W-1:0];
      end
   end

   // Sequencer: decides each cycle which read, write or compare the datapath does.
   btnode_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Entry memories, entry count and the response register.
   btnode_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BITS    (KEY_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_op        (req_chan.op),
      .req_key       (req_chan.search_key),
      .req_new_child (req_chan.new_child),
      .req_anchor    (req_chan.anchor_child),
      .req_slot      (req_chan.slot),
      .max_entries   (max_ff),
      .out_child     (rsp_chan.found_child),
      .out_key       (rsp_chan.found_key),
      .out_slot      (rsp_chan.found_slot),
      .out_total     (rsp_chan.entry_total),
      .out_status    (rsp_chan.status)
   );

endmodule

// ===== sv/btnode_dp.sv =====
// Datapath: entry memories, entry count, scan index and result registers.
module btnode_dp #(
   parameter int MAX_ENTRIES = btnode_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_BITS    = btnode_pkg::KEY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  btnode_pkg::cmd_type                  cmd,
   output btnode_pkg::stat_type                 stat,
   input  logic [btnode_pkg::OP_W-1:0]          req_op,
   input  logic signed [btnode_pkg::KEY_W-1:0]  req_key,
   input  logic [btnode_pkg::CHILD_W-1:0]       req_new_child,
   input  logic [btnode_pkg::CHILD_W-1:0]       req_anchor,
   input  logic [btnode_pkg::SLOT_W-1:0]        req_slot,
   input  logic [btnode_pkg::CFG_W-1:0]         max_entries,
   output logic [btnode_pkg::CHILD_W-1:0]       out_child,
   output logic signed [btnode_pkg::KEY_W-1:0]  out_key,
   output logic [btnode_pkg::SLOT_W-1:0]        out_slot,
   output logic [btnode_pkg::SLOT_W-1:0]        out_total,
   output logic [btnode_pkg::STAT_W-1:0]        out_status
);
   localparam int ROWS = MAX_ENTRIES + 1;
   localparam int AW   = $clog2(ROWS);
   localparam int CW   = $clog2(ROWS + 1);
   localparam int SW   = (CW > btnode_pkg::SLOT_W) ? CW : btnode_pkg::SLOT_W;
   localparam int CHW  = btnode_pkg::CHILD_W;

   logic [KEY_BITS-1:0] key_mem   [ROWS];
   logic [CHW-1:0]      child_mem [ROWS];

   logic [btnode_pkg::OP_W-1:0]     op_ff;
   logic signed [KEY_BITS-1:0]      key_ff;
   logic [CHW-1:0]                  nchild_ff;
   logic [CHW-1:0]                  anchor_ff;
   logic [btnode_pkg::SLOT_W-1:0]   slot_ff;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   idx_ff;
   logic [CW-1:0]                   best_ff;
   logic [CW-1:0]                   pos_ff;
   logic [KEY_BITS-1:0]             rdk_ff;
   logic [CHW-1:0]                  rdc_ff;
   logic [CHW-1:0]                  res_child_ff;
   logic [btnode_pkg::KEY_W-1:0]    res_key_ff;
   logic [btnode_pkg::SLOT_W-1:0]   res_slot_ff;
   logic [btnode_pkg::STAT_W-1:0]   res_status_ff;

   logic [CW-1:0]       idx_m1, idx_p1, at;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                wr_key_en, wr_child_en;
   logic [KEY_BITS-1:0] wr_key_data;
   logic [CHW-1:0]      wr_child_data;
   logic [SW-1:0]       slot_x, count_x, max_x, cap_m;
   logic                key_le;

   assign idx_m1 = idx_ff - CW'(1);
   assign idx_p1 = idx_ff + CW'(1);
   assign at     = pos_ff + CW'(1);
   assign key_le = $signed(rdk_ff) <= key_ff;

   always_comb begin
      case (cmd.rd_src)
         btnode_pkg::RD_IDX:    rd_addr = idx_ff[AW-1:0];
         btnode_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
         btnode_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
         btnode_pkg::RD_BEST:   rd_addr = best_ff[AW-1:0];
         btnode_pkg::RD_SLOT:   rd_addr = AW'(slot_ff);
         default:               rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_addr       = idx_ff[AW-1:0];
      wr_key_en     = 1'b0;
      wr_child_en   = 1'b0;
      wr_key_data   = key_ff;
      wr_child_data = nchild_ff;
      case (cmd.wr_kind)
         btnode_pkg::WR_SHIFT: begin
            wr_key_en     = 1'b1;
            wr_child_en   = 1'b1;
            wr_key_data   = rdk_ff;
            wr_child_data = rdc_ff;
         end
         btnode_pkg::WR_INS: begin
            wr_addr     = at[AW-1:0];
            wr_key_en   = 1'b1;
            wr_child_en = 1'b1;
         end
         btnode_pkg::WR_ROOT0: begin
            wr_addr       = '0;
            wr_child_en   = 1'b1;
            wr_child_data = anchor_ff;
         end
         btnode_pkg::WR_ROOT1: begin
            wr_addr     = AW'(1);
            wr_key_en   = 1'b1;
            wr_child_en = 1'b1;
         end
         btnode_pkg::WR_SETKEY: begin
            wr_addr   = AW'(slot_ff);
            wr_key_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key_data;
      end
      if (wr_child_en) begin
         child_mem[wr_addr] <= wr_child_data;
      end
      if (cmd.rd_en) begin
         rdk_ff <= key_mem[rd_addr];
         rdc_ff <= child_mem[rd_addr];
      end
   end

   // capacity is min(max_entries, MAX_ENTRIES) + 1
   assign slot_x  = SW'(slot_ff);
   assign count_x = SW'(count_ff);
   assign max_x   = SW'(max_entries);
   assign cap_m   = (max_x > SW'(MAX_ENTRIES)) ? SW'(MAX_ENTRIES) : max_x;

   always_comb begin
      stat.op         = op_ff;
      stat.count_zero = count_ff == '0;
      stat.count_one  = count_ff == CW'(1);
      stat.slot_bad   = slot_x >= count_x;
      stat.full       = count_x > cap_m;
      stat.scan_end   = idx_ff >= count_ff;
      stat.child_hit  = rdc_ff == anchor_ff;
      stat.ins_done   = idx_ff == at;
      stat.rem_done   = idx_p1 >= count_ff;
   end

   always_comb begin
      case (cmd.cnt_op)
         btnode_pkg::CN_INC:  count_in = count_ff + CW'(1);
         btnode_pkg::CN_DEC:  count_in = count_ff - CW'(1);
         btnode_pkg::CN_TWO:  count_in = CW'(2);
         btnode_pkg::CN_ZERO: count_in = '0;
         default:             count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         key_ff    <= KEY_BITS'($signed(req_key));
         nchild_ff <= req_new_child;
         anchor_ff <= req_anchor;
         slot_ff   <= req_slot;
         best_ff   <= '0;
      end else if (cmd.cmp_key && key_le) begin
         best_ff <= idx_ff;
      end

      if (cmd.idx_set) begin
         case (cmd.idx_src)
            btnode_pkg::IX_ONE:   idx_ff <= CW'(1);
            btnode_pkg::IX_ZERO:  idx_ff <= '0;
            btnode_pkg::IX_COUNT: idx_ff <= count_ff;
            default:              idx_ff <= CW'(slot_ff);
         endcase
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_p1;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_m1;
      end

      if (cmd.pos_load) begin
         pos_ff <= idx_ff;
      end

      if (cmd.load) begin
         res_child_ff  <= '0;
         res_key_ff    <= '0;
         res_slot_ff   <= '0;
         res_status_ff <= btnode_pkg::ST_OK;
      end else begin
         if (cmd.res_child) begin
            res_child_ff <= rdc_ff;
         end
         if (cmd.res_key) begin
            res_key_ff <= btnode_pkg::KEY_W'($signed(rdk_ff));
         end
         if (cmd.res_slot_idx) begin
            res_slot_ff <= btnode_pkg::SLOT_W'(idx_ff);
         end else if (cmd.res_slot_at) begin
            res_slot_ff <= btnode_pkg::SLOT_W'(at);
         end
         if (cmd.status_set) begin
            res_status_ff <= cmd.status;
         end
      end

      if (cmd.out_load) begin
         out_child  <= res_child_ff;
         out_key    <= res_key_ff;
         out_slot   <= res_slot_ff;
         out_total  <= btnode_pkg::SLOT_W'(count_ff);
         out_status <= res_status_ff;
      end
   end

endmodule

// ===== sv/btnode_ctl.sv =====
// Controller: sequences each operation over the datapath and owns the handshakes.
module btnode_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  btnode_pkg::stat_type stat,
   output btnode_pkg::cmd_type  cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_LK_CHK = 4'd2;
   localparam logic [3:0] S_LK_CMP = 4'd3;
   localparam logic [3:0] S_FD_CHK = 4'd4;
   localparam logic [3:0] S_FD_CMP = 4'd5;
   localparam logic [3:0] S_IN_CHK = 4'd6;
   localparam logic [3:0] S_IN_MV  = 4'd7;
   localparam logic [3:0] S_IN_WR  = 4'd8;
   localparam logic [3:0] S_RM_CHK = 4'd9;
   localparam logic [3:0] S_RM_MV  = 4'd10;
   localparam logic [3:0] S_ROOT1  = 4'd11;
   localparam logic [3:0] S_RES    = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.op)
               btnode_pkg::OP_LOOKUP: begin
                  if (stat.count_zero) begin
                     cmd.status_set = 1'b1;
                     cmd.status     = btnode_pkg::ST_EMPTY;
                     state_in       = S_FIN;
                  end else begin
                     cmd.idx_set = 1'b1;
                     cmd.idx_src = btnode_pkg::IX_ONE;
                     state_in    = S_LK_CHK;
                  end
               end
               btnode_pkg::OP_INSERT, btnode_pkg::OP_FIND_CHILD: begin
                  cmd.idx_set = 1'b1;
                  cmd.idx_src = btnode_pkg::IX_ZERO;
                  state_in    = S_FD_CHK;
               end
               btnode_pkg::OP_REMOVE: begin
                  if (stat.slot_bad) begin
                     cmd.status_set = 1'b1;
                     cmd.status     = btnode_pkg::ST_BAD_INDEX;
                     state_in       = S_FIN;
                  end else begin
                     cmd.idx_set = 1'b1;
                     cmd.idx_src = btnode_pkg::IX_SLOT;
                     state_in    = S_RM_CHK;
                  end
               end
               btnode_pkg::OP_NEW_ROOT: begin
                  cmd.wr_kind = btnode_pkg::WR_ROOT0;
                  state_in    = S_ROOT1;
               end
               btnode_pkg::OP_READ: begin
                  if (stat.slot_bad) begin
                     cmd.status_set = 1'b1;
                     cmd.status     = btnode_pkg::ST_BAD_INDEX;
                     state_in       = S_FIN;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_src = btnode_pkg::RD_SLOT;
                     state_in   = S_RES;
                  end
               end
               btnode_pkg::OP_SET_KEY: begin
                  if (stat.slot_bad) begin
                     cmd.status_set = 1'b1;
                     cmd.status     = btnode_pkg::ST_BAD_INDEX;
                  end else begin
                     cmd.wr_kind = btnode_pkg::WR_SETKEY;
                  end
                  state_in = S_FIN;
               end
               default: begin
                  if (stat.count_zero) begin
                     cmd.status_set = 1'b1;
                     cmd.status     = btnode_pkg::ST_EMPTY;
                     state_in       = S_FIN;
                  end else if (!stat.count_one) begin
                     cmd.status_set = 1'b1;
                     cmd.status     = btnode_pkg::ST_BAD_INDEX;
                     state_in       = S_FIN;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_src = btnode_pkg::RD_ZERO;
                     cmd.cnt_op = btnode_pkg::CN_ZERO;
                     state_in   = S_RES;
                  end
               end
            endcase
         end
         S_LK_CHK: begin
            cmd.rd_en = 1'b1;
            if (stat.scan_end) begin
               cmd.rd_src = btnode_pkg::RD_BEST;
               state_in   = S_RES;
            end else begin
               cmd.rd_src = btnode_pkg::RD_IDX;
               state_in   = S_LK_CMP;
            end
         end
         S_LK_CMP: begin
            cmd.cmp_key = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_LK_CHK;
         end
         S_FD_CHK: begin
            if (stat.scan_end) begin
               cmd.status_set = 1'b1;
               cmd.status     = btnode_pkg::ST_NOT_FOUND;
               state_in       = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = btnode_pkg::RD_IDX;
               state_in   = S_FD_CMP;
            end
         end
         S_FD_CMP: begin
            if (!stat.child_hit) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_FD_CHK;
            end else if (stat.op == btnode_pkg::OP_FIND_CHILD) begin
               cmd.res_slot_idx = 1'b1;
               state_in         = S_FIN;
            end else if (stat.full) begin
               cmd.status_set = 1'b1;
               cmd.status     = btnode_pkg::ST_FULL;
               state_in       = S_FIN;
            end else begin
               cmd.pos_load = 1'b1;
               cmd.idx_set  = 1'b1;
               cmd.idx_src  = btnode_pkg::IX_COUNT;
               state_in     = S_IN_CHK;
            end
         end
         S_IN_CHK: begin
            if (stat.ins_done) begin
               state_in = S_IN_WR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = btnode_pkg::RD_IDX_M1;
               state_in   = S_IN_MV;
            end
         end
         S_IN_MV: begin
            cmd.wr_kind = btnode_pkg::WR_SHIFT;
            cmd.idx_dec = 1'b1;
            state_in    = S_IN_CHK;
         end
         S_IN_WR: begin
            cmd.wr_kind     = btnode_pkg::WR_INS;
            cmd.cnt_op      = btnode_pkg::CN_INC;
            cmd.res_slot_at = 1'b1;
            state_in        = S_FIN;
         end
         S_RM_CHK: begin
            if (stat.rem_done) begin
               cmd.cnt_op = btnode_pkg::CN_DEC;
               state_in   = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = btnode_pkg::RD_IDX_P1;
               state_in   = S_RM_MV;
            end
         end
         S_RM_MV: begin
            cmd.wr_kind = btnode_pkg::WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_RM_CHK;
         end
         S_ROOT1: begin
            cmd.wr_kind = btnode_pkg::WR_ROOT1;
            cmd.cnt_op  = btnode_pkg::CN_TWO;
            state_in    = S_FIN;
         end
         S_RES: begin
            cmd.res_child = 1'b1;
            cmd.res_key   = stat.op == btnode_pkg::OP_READ;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/btnode_chk.sv =====
// Port-level checker for the node table, bound to the top level.
module btnode_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [btnode_pkg::CHILD_W-1:0]    found_child,
   input logic [btnode_pkg::SLOT_W-1:0]     entry_total,
   input logic [btnode_pkg::STAT_W-1:0]     status
);
   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_total))
      else $error("response changed while stalled");

   // one transaction in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // empty status reports an empty node and no child
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == btnode_pkg::ST_EMPTY |-> entry_total == '0 && found_child == '0)
      else $error("empty status with entries or child");

   // no response right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind btree_internal_node_table btnode_chk u_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .found_child (rsp_chan.found_child),
   .entry_total (rsp_chan.entry_total),
   .status      (rsp_chan.status)
);
